// ===== design/kfc_pkg.sv =====
// Shared types, codes and constants for the keyword frequency counter.
// No dependencies; imported by every module of the block.
package kfc_pkg;

    // Operation carried in the tuser of each input item
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TEXT  = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } kfc_op_t;

    localparam int SLOT_FIELD_W = 3;
    localparam int POS_FIELD_W  = 6;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 16;
    localparam int MASK_W       = 8;

    localparam logic [BYTE_W-1:0]  CHAR_UPPER_A = 8'd65;
    localparam logic [BYTE_W-1:0]  CHAR_UPPER_Z = 8'd90;
    localparam logic [BYTE_W-1:0]  CHAR_LOWER_A = 8'd97;
    localparam logic [BYTE_W-1:0]  CHAR_LOWER_Z = 8'd122;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

    typedef struct packed {
        kfc_op_t                 opcode;
        logic [SLOT_FIELD_W-1:0] keyword_slot;
        logic [POS_FIELD_W-1:0]  char_position;
        logic [BYTE_W-1:0]       data_byte;
    } kfc_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] counter_value;
        logic [MASK_W-1:0]  match_mask;
        logic               word_ended;
    } kfc_result_t;

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
               ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z));
    endfunction

endpackage

// ===== design/kfc_store.sv =====
// Keyword store: one row per character position, one byte lane per slot.
// Depends on kfc_pkg. Holds the clearing pass that runs after reset.
module kfc_store
    import kfc_pkg::*;
#(
    parameter int NUM_KEYWORDS = 8,
    parameter int WORD_LEN     = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 ld_en,
    input  logic [$clog2(NUM_KEYWORDS+1)-1:0]    ld_slot,
    input  logic [$clog2(WORD_LEN+1)-1:0]        ld_row,
    input  logic [BYTE_W-1:0]                    ld_byte,
    input  logic [$clog2(WORD_LEN+1)-1:0]        rd_row,
    output logic [NUM_KEYWORDS-1:0][BYTE_W-1:0]  rd_bytes,
    output logic                                 clearing
);

    localparam int DEPTH = WORD_LEN + 1;
    localparam int ROW_W = $clog2(WORD_LEN + 1);
    localparam int SEL_W = $clog2(NUM_KEYWORDS + 1);

    logic [NUM_KEYWORDS-1:0][BYTE_W-1:0] mem [DEPTH];

    logic                                clearing_reg;
    logic [ROW_W-1:0]                    clr_row_reg;
    logic [NUM_KEYWORDS-1:0][BYTE_W-1:0] rd_mem_reg;
    logic [NUM_KEYWORDS-1:0]             fwd_hit_reg;
    logic [BYTE_W-1:0]                   fwd_byte_reg;

    logic                    wr_en;
    logic [ROW_W-1:0]        wr_row;
    logic [NUM_KEYWORDS-1:0] wr_be;
    logic [BYTE_W-1:0]       wr_byte;

    always_comb
    begin
        wr_en   = clearing_reg || ld_en;
        wr_row  = clearing_reg ? clr_row_reg : ld_row;
        wr_byte = clearing_reg ? '0 : ld_byte;
        for (int s = 0; s < NUM_KEYWORDS; s++)
        begin
            wr_be[s] = clearing_reg || (ld_slot == SEL_W'(s));
        end
    end

    // Sweep every row to zero, one row a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_row_reg == ROW_W'(WORD_LEN))
            begin
                clearing_reg <= 1'b0;
            end
            else
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int s = 0; s < NUM_KEYWORDS; s++)
            begin
                if (wr_be[s])
                begin
                    mem[wr_row][s] <= wr_byte;
                end
            end
        end
    end

    // Registered read, with the same-cycle write forwarded per lane
    always_ff @(posedge clk)
    begin
        rd_mem_reg   <= mem[rd_row];
        fwd_byte_reg <= wr_byte;
        for (int s = 0; s < NUM_KEYWORDS; s++)
        begin
            fwd_hit_reg[s] <= wr_en && wr_be[s] && (wr_row == rd_row);
        end
    end

    always_comb
    begin
        for (int s = 0; s < NUM_KEYWORDS; s++)
        begin
            rd_bytes[s] = fwd_hit_reg[s] ? fwd_byte_reg : rd_mem_reg[s];
        end
    end

    assign clearing = clearing_reg;

endmodule

// ===== design/kfc_match.sv =====
// Word tracker and per-slot match lanes with saturating hit counters.
// Depends on kfc_pkg; takes the keyword bytes at the current word position.
module kfc_match
    import kfc_pkg::*;
#(
    parameter int NUM_KEYWORDS = 8,
    parameter int WORD_LEN     = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  kfc_item_t                           item,
    input  logic [3:0]                          active_keywords,
    input  logic [NUM_KEYWORDS-1:0][BYTE_W-1:0] kw_bytes,
    output logic [$clog2(WORD_LEN+1)-1:0]       word_length_next,
    output kfc_result_t                         result
);

    localparam int LEN_W = $clog2(WORD_LEN + 1);
    localparam int IDX_W = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;

    logic [LEN_W-1:0]        word_length_reg;
    logic                    word_too_long_reg;
    logic [NUM_KEYWORDS-1:0] still_matching_reg;
    logic [COUNT_W-1:0]      hit_counters_reg [NUM_KEYWORDS];

    logic                    word_too_long_next;
    logic [NUM_KEYWORDS-1:0] still_matching_next;
    logic [NUM_KEYWORDS-1:0] hit;
    logic                    is_text;
    logic                    letter;
    logic [IDX_W-1:0]        slot_sel;

    assign is_text  = (item.opcode == OP_TEXT);
    assign letter   = is_letter(item.data_byte);
    assign slot_sel = IDX_W'(item.keyword_slot);

    always_comb
    begin
        word_length_next    = word_length_reg;
        word_too_long_next  = word_too_long_reg;
        still_matching_next = still_matching_reg;
        hit                 = '0;
        if (go && is_text)
        begin
            if (letter)
            begin
                if (!word_too_long_reg && (32'(word_length_reg) < WORD_LEN))
                begin
                    for (int s = 0; s < NUM_KEYWORDS; s++)
                    begin
                        if (kw_bytes[s] != item.data_byte)
                        begin
                            still_matching_next[s] = 1'b0;
                        end
                    end
                    word_length_next = word_length_reg + 1'b1;
                end
                else
                begin
                    word_too_long_next = 1'b1;
                end
            end
            else
            begin
                // Word ends here: a slot hits when its keyword ends at the same place
                for (int s = 0; s < NUM_KEYWORDS; s++)
                begin
                    hit[s] = !word_too_long_reg && still_matching_reg[s] &&
                             (kw_bytes[s] == '0) &&
                             (32'(s) < 32'(active_keywords));
                end
                word_length_next    = '0;
                word_too_long_next  = 1'b0;
                still_matching_next = '1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg    <= '0;
            word_too_long_reg  <= 1'b0;
            still_matching_reg <= '1;
            for (int s = 0; s < NUM_KEYWORDS; s++)
            begin
                hit_counters_reg[s] <= '0;
            end
        end
        else
        begin
            word_length_reg    <= word_length_next;
            word_too_long_reg  <= word_too_long_next;
            still_matching_reg <= still_matching_next;
            for (int s = 0; s < NUM_KEYWORDS; s++)
            begin
                if (go && (item.opcode == OP_CLEAR))
                begin
                    hit_counters_reg[s] <= '0;
                end
                else if (hit[s] && (hit_counters_reg[s] != COUNT_MAX))
                begin
                    hit_counters_reg[s] <= hit_counters_reg[s] + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result = '0;
        if ((item.opcode == OP_READ) && (32'(item.keyword_slot) < NUM_KEYWORDS))
        begin
            result.counter_value = hit_counters_reg[slot_sel];
        end
        for (int s = 0; s < NUM_KEYWORDS; s++)
        begin
            if (s < MASK_W)
            begin
                result.match_mask[s] = hit[s];
            end
        end
        result.word_ended = is_text && !letter;
    end

endmodule

// ===== design/keyword_frequency_counter.sv =====
// Top level of the keyword frequency counter: stream ports, input and result registers.
// Depends on kfc_pkg, kfc_store and kfc_match.
//
// The block splits a byte stream into words (runs of A-Z and a-z; any other byte
// ends a word, an empty word included) and counts, per keyword slot, how many
// words match that slot's keyword exactly and case-sensitively. Each input item
// carries an operation in tuser: load one keyword byte at a slot and position
// (a zero byte terminates the keyword), stream one text byte, read one slot's
// 16-bit saturating counter, or clear all counters. Every item yields exactly
// one result item: the counter on a read, the slot match mask and a word-ended
// flag when a text byte ends a word, zeros otherwise. Only slots below
// active_keywords take part in matching. One item is taken every clock cycle
// unless the sweep runs or a result waits in the output register; an item
// is held in the input register, where the compare against all slots runs in
// parallel on the keyword byte read at the current word position, and its
// result is then held in the output register until taken. The keyword store
// is a memory with one row per character position; after reset it is swept
// to zero one row a cycle, and s_axis_tready stays low during the sweep
// (configuration writes are taken meanwhile). Write active_keywords
// only while the block is idle.
module keyword_frequency_counter
    import kfc_pkg::*;
#(
    parameter int NUM_KEYWORDS = 8,
    parameter int WORD_LEN     = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,      // active_keywords
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // keyword_slot[2:0], char_position[8:3],
                                        // data_byte[16:9], zero fill
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // counter_value[15:0], match_mask[23:16]
    output logic [0:0]  m_axis_tuser    // word_ended[0]
);

    localparam int ROW_W = $clog2(WORD_LEN + 1);
    localparam int SEL_W = $clog2(NUM_KEYWORDS + 1);

    logic [3:0]  active_keywords_reg;
    logic        in_valid_reg;
    kfc_item_t   in_item_reg;
    logic        out_valid_reg;
    kfc_result_t out_result_reg;

    logic        accept;
    logic        advance;
    logic        clearing;
    logic        ld_en;
    kfc_item_t   item_in;
    kfc_result_t result;

    logic [NUM_KEYWORDS-1:0][BYTE_W-1:0] kw_bytes;
    logic [ROW_W-1:0]                    word_length_next;

    // Unpack the incoming item
    always_comb
    begin
        item_in.opcode        = kfc_op_t'(s_axis_tuser);
        item_in.keyword_slot  = s_axis_tdata[2:0];
        item_in.char_position = s_axis_tdata[8:3];
        item_in.data_byte     = s_axis_tdata[16:9];
    end

    // Advance the held item into the result register whenever that has room
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !clearing && (!in_valid_reg || advance);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Drop loads that fall outside the store
    assign ld_en = advance && (in_item_reg.opcode == OP_LOAD) &&
                   (32'(in_item_reg.keyword_slot) < NUM_KEYWORDS) &&
                   (32'(in_item_reg.char_position) <= WORD_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_keywords_reg <= '0;
        end
        else if (cfg_we)
        begin
            active_keywords_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold until the next accept or advance
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg <= item_in;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    kfc_store #(
        .NUM_KEYWORDS (NUM_KEYWORDS),
        .WORD_LEN     (WORD_LEN)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld_en    (ld_en),
        .ld_slot  (SEL_W'(in_item_reg.keyword_slot)),
        .ld_row   (ROW_W'(in_item_reg.char_position)),
        .ld_byte  (in_item_reg.data_byte),
        .rd_row   (word_length_next),
        .rd_bytes (kw_bytes),
        .clearing (clearing)
    );

    kfc_match #(
        .NUM_KEYWORDS (NUM_KEYWORDS),
        .WORD_LEN     (WORD_LEN)
    ) u_match (
        .clk              (clk),
        .rst_n            (rst_n),
        .go               (advance),
        .item             (in_item_reg),
        .active_keywords  (active_keywords_reg),
        .kw_bytes         (kw_bytes),
        .word_length_next (word_length_next),
        .result           (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_result_reg.match_mask, out_result_reg.counter_value};
    assign m_axis_tuser  = out_result_reg.word_ended;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for keyword_frequency_counter: directed and random items on the stream ports.
// Depends on kfc_pkg for the item codes and constants; the expected tallies come from its own predictor.
module testbench
    import kfc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_KW          = 8;
    localparam int WORD_LEN_P      = 32;
    localparam int SLOT_BYTES      = WORD_LEN_P + 1;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RUN_WORDS       = 64;
    localparam int PHASE_ITEMS     = 160;
    localparam string ALPHA        = "aAbBgGoOzZ";

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;      // active_keywords
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // keyword_slot[2:0], char_position[8:3], data_byte[16:9]
    logic [1:0]  s_axis_tuser;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // counter_value[15:0], match_mask[23:16]
    logic [0:0]  m_axis_tuser;   // word_ended[0]

    // Predictor state: keyword table, hit counters and the word in progress
    logic [7:0]        kw_bytes [NUM_KW][SLOT_BYTES];
    logic [15:0]       hit_count [NUM_KW];
    bit [NUM_KW-1:0]   word_live;
    int                cur_len;
    bit                cur_overlong;
    logic [3:0]        active_slots;

    kfc_result_t       expected_tallies [$];
    string             kw_text [NUM_KW];   // keyword last loaded per slot, for stimulus only
    int                errors;
    int                stalled_cycles;
    int                hold_off_left;
    int unsigned       burst_left;
    bit                gaps_enabled;
    longint            items_sent;

    keyword_frequency_counter #(
        .NUM_KEYWORDS (NUM_KW),
        .WORD_LEN     (WORD_LEN_P)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic bit is_alpha(input logic [7:0] b);
        return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
               ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z));
    endfunction

    // Open a fresh word: every slot is a candidate again
    function automatic void restart_word();
        word_live    = '1;
        cur_len      = 0;
        cur_overlong = 1'b0;
    endfunction

    // Apply one item to the predictor state and return the result it yields
    function automatic kfc_result_t tally_keywords(input kfc_item_t it);
        kfc_result_t r;
        int          lim;
        r = '0;
        case (it.opcode)
            OP_LOAD:
            begin
                // Positions beyond the terminator slot are dropped
                if (int'(it.char_position) <= WORD_LEN_P)
                    kw_bytes[it.keyword_slot][it.char_position] = it.data_byte;
            end
            OP_TEXT:
            begin
                if (is_alpha(it.data_byte))
                begin
                    // Compare this letter against every slot; past WORD_LEN mark the word dead
                    if (!cur_overlong && cur_len < WORD_LEN_P)
                    begin
                        for (int s = 0; s < NUM_KW; s++)
                            if (kw_bytes[s][cur_len] != it.data_byte)
                                word_live[s] = 1'b0;
                        cur_len++;
                    end
                    else
                    begin
                        cur_overlong = 1'b1;
                    end
                end
                else
                begin
                    // Delimiter: close the word, an empty one included
                    lim = (int'(active_slots) < NUM_KW) ? int'(active_slots) : NUM_KW;
                    r.word_ended = 1'b1;
                    if (!cur_overlong && cur_len <= WORD_LEN_P)
                    begin
                        for (int s = 0; s < lim; s++)
                        begin
                            if (word_live[s] && kw_bytes[s][cur_len] == 8'd0)
                            begin
                                if (hit_count[s] != COUNT_MAX)
                                    hit_count[s] = hit_count[s] + 16'd1;
                                r.match_mask[s] = 1'b1;
                            end
                        end
                    end
                    restart_word();
                end
            end
            OP_READ:
            begin
                r.counter_value = hit_count[it.keyword_slot];
            end
            OP_CLEAR:
            begin
                // Counters only; the word in progress carries on
                for (int s = 0; s < NUM_KW; s++)
                    hit_count[s] = '0;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one item per call, bursts with random gaps between them
    // ------------------------------------------------------------------

    task automatic send_item(input kfc_op_t op, input logic [2:0] slot,
                             input logic [5:0] pos, input logic [7:0] b);
        kfc_item_t   it;
        int unsigned gap;
        it.opcode        = op;
        it.keyword_slot  = slot;
        it.char_position = pos;
        it.data_byte     = b;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, b, pos, slot};
        s_axis_tuser  <= op;
        // Hold the item until the block takes it
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_tallies.push_back(tally_keywords(it));
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (gaps_enabled && burst_left == 0)
        begin
            // Mostly short bursts, now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_tallies.size() != 0)
            @(posedge clk);
    endtask

    // Write active_keywords; only called with the block idle
    task automatic write_active(input logic [3:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        active_slots = v;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Load a keyword byte by byte and close it with a zero byte
    task automatic load_keyword(input logic [2:0] slot, input string k);
        for (int i = 0; i < k.len(); i++)
            send_item(OP_LOAD, slot, 6'(i), k[i]);
        send_item(OP_LOAD, slot, 6'(k.len()), 8'd0);
        kw_text[slot] = k;
    endtask

    // Stream a word followed by one delimiter; the unused fields carry noise
    task automatic send_word(input string w, input logic [7:0] delim);
        for (int i = 0; i < w.len(); i++)
            send_item(OP_TEXT, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), w[i]);
        send_item(OP_TEXT, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)), delim);
    endtask

    function automatic string repeat_char(input string c, input int n);
        string s;
        s = "";
        repeat (n) s = {s, c};
        return s;
    endfunction

    function automatic string random_letters(input int n);
        string s;
        int    k;
        s = "";
        repeat (n)
        begin
            k = $urandom_range(0, ALPHA.len() - 1);
            s = {s, ALPHA.substr(k, k)};
        end
        return s;
    endfunction

    function automatic logic [7:0] random_delim();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_alpha(b));
        return b;
    endfunction

    // Half loaded keywords, so that matches are frequent; the rest random, trimmed, extended, overlong or empty
    function automatic string random_word();
        int    pick;
        string w;
        pick = $urandom_range(0, 99);
        w    = kw_text[$urandom_range(0, NUM_KW - 1)];
        if (pick < 50)
            return w;
        else if (pick < 70)
            return random_letters($urandom_range(1, 5));
        else if (pick < 80)
            return (w.len() > 1 && pick < 75) ? w.substr(0, w.len() - 2)
                                              : {w, random_letters(1)};
        else if (pick < 90)
            return random_letters($urandom_range(30, 35));
        return "";
    endfunction

    function automatic string random_keyword();
        if ($urandom_range(0, 9) != 0)
            return random_letters($urandom_range(0, 6));
        return random_letters($urandom_range(31, 33));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty words match every active slot that was never loaded
    task automatic test_empty_word();
        write_active(4'd8);
        send_item(OP_TEXT, 3'd0, 6'd0, 8'h20);
        send_item(OP_TEXT, 3'd7, 6'd63, 8'h00);
        send_item(OP_TEXT, 3'd0, 6'd0, 8'hFF);
        send_item(OP_READ, 3'd0, 6'd0, 8'd0);
        send_item(OP_READ, 3'd7, 6'd0, 8'd0);
        wait_for_results();
    endtask

    // Case-sensitive whole-word matches, letter range edges, ignored loads
    task automatic test_keyword_match();
        load_keyword(3'd0, "Go");
        load_keyword(3'd1, "go");
        load_keyword(3'd2, "AZaz");
        // Positions past the terminator slot are ignored
        send_item(OP_LOAD, 3'd0, 6'd33, 8'h78);
        send_item(OP_LOAD, 3'd0, 6'd63, 8'hFF);
        send_word("Go", 8'h40);
        send_word("go", 8'h5B);
        send_word("GO", 8'h60);
        send_word("AZaz", 8'h7B);
        send_word("Gog", 8'h20);
        for (int s = 0; s < 3; s++)
            send_item(OP_READ, 3'(s), 6'd0, 8'd0);
        wait_for_results();
    endtask

    // Clear zeroes counters but leaves the word in progress alone
    task automatic test_clear();
        send_item(OP_TEXT, 3'd0, 6'd0, "G");
        send_item(OP_CLEAR, 3'd0, 6'd0, 8'd0);
        send_word("o", 8'h2E);
        send_item(OP_READ, 3'd0, 6'd0, 8'd0);
        send_item(OP_READ, 3'd1, 6'd0, 8'd0);
        wait_for_results();
    endtask

    // Loads during a word: earlier compares stand, later bytes see new contents
    task automatic test_load_mid_word();
        send_item(OP_TEXT, 3'd0, 6'd0, "G");
        send_item(OP_LOAD, 3'd0, 6'd1, "x");
        send_word("x", 8'h20);
        send_item(OP_TEXT, 3'd0, 6'd0, "G");
        send_item(OP_LOAD, 3'd0, 6'd0, "Q");
        send_word("x", 8'h20);
        kw_text[0] = "Qx";
        send_item(OP_READ, 3'd0, 6'd0, 8'd0);
        wait_for_results();
    endtask

    // Keywords of WORD_LEN letters, unterminated keywords and overlong words
    task automatic test_long_words();
        load_keyword(3'd3, repeat_char("q", SLOT_BYTES));
        load_keyword(3'd4, repeat_char("q", WORD_LEN_P));
        send_word(repeat_char("q", WORD_LEN_P), 8'h20);
        send_word(repeat_char("q", WORD_LEN_P + 1), 8'h20);
        send_word(repeat_char("q", WORD_LEN_P + 2), 8'h2C);
        send_item(OP_READ, 3'd3, 6'd0, 8'd0);
        send_item(OP_READ, 3'd4, 6'd0, 8'd0);
        wait_for_results();
    endtask

    // Active slot counts at both ends and above the slot count
    task automatic test_active_range();
        write_active(4'd0);
        send_word("", 8'h20);
        wait_for_results();
        write_active(4'd15);
        send_word("", 8'h20);
        wait_for_results();
        write_active(4'd9);
        send_word("Qx", 8'h20);
        wait_for_results();
        write_active(4'd1);
        send_word("", 8'h20);
        wait_for_results();
    endtask

    // Count a run of back-to-back empty words on slot 0, then clear it
    task automatic test_counter_run();
        load_keyword(3'd0, "");
        send_item(OP_CLEAR, 3'd0, 6'd0, 8'd0);
        gaps_enabled = 1'b0;
        repeat (RUN_WORDS) send_item(OP_TEXT, 3'd0, 6'd0, random_delim());
        gaps_enabled = 1'b1;
        send_item(OP_READ, 3'd0, 6'd0, 8'd0);
        send_item(OP_CLEAR, 3'd0, 6'd0, 8'd0);
        send_item(OP_READ, 3'd0, 6'd0, 8'd0);
        wait_for_results();
    endtask

    // Hold the receiver off for a long stretch while items keep coming
    task automatic test_backpressure();
        write_active(4'd8);
        hold_off_left = HOLD_OFF_CYCLES;
        repeat (12) send_word(random_word(), random_delim());
        wait_for_results();
    endtask

    // Random traffic: mostly keyword loads and words, with reads, clears and noise
    task automatic test_random_traffic(input logic [3:0] act, input int n);
        longint start;
        int     pick;
        wait_for_results();
        write_active(act);
        start = items_sent;
        while (items_sent - start < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                load_keyword(3'($urandom_range(0, 7)), random_keyword());
            else if (pick < 62)
                send_word(random_word(), random_delim());
            else if (pick < 77)
                send_item(OP_READ, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
            else if (pick < 80)
                send_item(OP_CLEAR, 3'($urandom_range(0, 7)), 6'($urandom_range(0, 63)),
                          8'($urandom_range(0, 255)));
            else
                send_item(kfc_op_t'(2'($urandom_range(0, 3))), 3'($urandom_range(0, 7)),
                          6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready pattern of its own, plus the long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin : result_sink
        int mode;
        int mode_left;
        bit rdy;
        mode      = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 128);
            end
            else
            begin
                mode_left--;
            end
            if (hold_off_left > 0)
            begin
                rdy = 1'b0;
                hold_off_left--;
            end
            else
            begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 4) != 0);
                    default: rdy = ((mode_left % 7) > 2);
                endcase
            end
            m_axis_tready <= rdy;
        end
    end

    // ------------------------------------------------------------------
    // Checker: each result against the oldest expectation, field by field
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        kfc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tallies.size() == 0)
            begin
                $display("%0t: unexpected result: counter %0d mask %02h ended %0d",
                         $time, m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tuser[0]);
                errors++;
            end
            else
            begin
                want = expected_tallies.pop_front();
                if (m_axis_tdata[15:0] !== want.counter_value)
                begin
                    $display("%0t: counter_value expected %0d actual %0d",
                             $time, want.counter_value, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[23:16] !== want.match_mask)
                begin
                    $display("%0t: match_mask expected %02h actual %02h",
                             $time, want.match_mask, m_axis_tdata[23:16]);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.word_ended)
                begin
                    $display("%0t: word_ended expected %0d actual %0d",
                             $time, want.word_ended, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge clk)
    begin : watchdog
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        m_axis_tready  = 1'b0;
        hold_off_left  = 0;
        burst_left     = 0;
        gaps_enabled   = 1'b1;
        items_sent     = 0;
        errors         = 0;
        stalled_cycles = 0;
        // Predictor starts from the reset state of the block
        for (int s = 0; s < NUM_KW; s++)
        begin
            for (int p = 0; p < SLOT_BYTES; p++)
                kw_bytes[s][p] = 8'd0;
            hit_count[s] = '0;
            kw_text[s]   = "";
        end
        active_slots = 4'd0;
        restart_word();

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The first item waits out the keyword table sweep through tready
        test_empty_word();
        test_keyword_match();
        test_clear();
        test_load_mid_word();
        test_long_words();
        test_active_range();
        test_counter_run();
        test_backpressure();
        test_random_traffic(4'd8, PHASE_ITEMS);
        test_random_traffic(4'd0, PHASE_ITEMS);
        test_random_traffic(4'd15, PHASE_ITEMS);
        test_random_traffic(4'($urandom_range(1, 7)), PHASE_ITEMS);
        test_random_traffic(4'($urandom_range(0, 15)), PHASE_ITEMS);

        // Let any stray result surface before the verdict
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_tallies.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, expected_tallies.size());
            errors++;
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
design/kfc_pkg.sv
design/kfc_store.sv
design/kfc_match.sv
design/keyword_frequency_counter.sv
dv/testbench.sv
